// File: hdl/tppc_pkg.sv
package tppc_pkg;

    // fixed-point constants
    localparam logic signed [31:0] K_Q_Q30     = 32'sd1073849209; // FAR/(FAR-NEAR), Q2.30
    localparam logic signed [34:0] K_NEARQ_Q16 = 35'sd6554;       // NEAR*Q, Q16.16
    localparam logic signed [22:0] K_FOURPI    = 23'sd1335088;    // 4/pi, Q1.20
    localparam logic [45:0]        K_NDC_LIM   = 46'h2000_0000_0000; // 2^45
    localparam logic signed [47:0] K_ONE_Q16   = 48'sd65536;

    // widths
    localparam int W_SUM   = 33;
    localparam int W_DEPTH = 35;
    localparam int W_NUM   = 43;
    localparam int W_NDC   = 47;
    localparam int N_QBITS = 46;

    // pipeline depths
    localparam int LAT_FRONT  = 5;
    localparam int LAT_DIV    = N_QBITS + 2;
    localparam int LAT_SCREEN = 2;
    localparam int LAT_TOTAL  = LAT_FRONT + LAT_DIV + LAT_SCREEN + 1;

    // register indexes
    localparam logic [2:0] REG_OFFSET_X = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z = 3'd2;
    localparam logic [2:0] REG_SCREEN_W = 3'd3;
    localparam logic [2:0] REG_SCREEN_H = 3'd4;
    localparam logic [2:0] REG_ASPECT   = 3'd5;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [31:0] scr_a_x;
        logic signed [31:0] scr_a_y;
        logic signed [31:0] scr_b_x;
        logic signed [31:0] scr_b_y;
        logic signed [31:0] scr_c_x;
        logic signed [31:0] scr_c_y;
        logic               draw_enable;
    } t_tri_out;

    // round(v / 2^s), half away from zero
    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] v,
                                                 input int unsigned s);
        logic [63:0] m;
        logic [63:0] h;
        m = v[63] ? 64'(-v) : 64'(v);
        h = 64'(1) << (s - 1);
        m = (m + h) >> s;
        f_rnd = v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

// File: hdl/triangle_perspective_project_cull.sv
// Pipeline: front, divide, screen and merge stages in order, from input beat to output beat.
// Throughput: one triangle per cycle; the whole pipeline advances together and holds
//   only while the output register is full and stalled.
// Reset (synchronous, active low): clears all stage valid bits and loads the register
//   defaults (offsets 0, 800x600 viewport, aspect 1.0).
module triangle_perspective_project_cull (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tppc_pkg::t_tri_in   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tppc_pkg::t_tri_out  o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tppc_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [31:0] r_off_x, r_off_y, r_off_z;
    logic [12:0]        r_scr_w, r_scr_h;
    logic [15:0]        r_aspect;
    logic [2:0]         reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_off_z  <= '0;
            r_scr_w  <= 13'd800;
            r_scr_h  <= 13'd600;
            r_aspect <= 16'd256;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_OFFSET_X: r_off_x  <= pwdata;
                REG_OFFSET_Y: r_off_y  <= pwdata;
                REG_OFFSET_Z: r_off_z  <= pwdata;
                REG_SCREEN_W: r_scr_w  <= pwdata[12:0];
                REG_SCREEN_H: r_scr_h  <= pwdata[12:0];
                REG_ASPECT:   r_aspect <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OFFSET_X: prdata = r_off_x;
            REG_OFFSET_Y: prdata = r_off_y;
            REG_OFFSET_Z: prdata = r_off_z;
            REG_SCREEN_W: prdata = {19'd0, r_scr_w};
            REG_SCREEN_H: prdata = {19'd0, r_scr_h};
            REG_ASPECT:   prdata = {16'd0, r_aspect};
            default:      prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Single global enable: every stage moves unless the output beat is held.
    logic                 en;
    logic [LAT_TOTAL-1:0] r_vld;

    assign en          = !r_vld[LAT_TOTAL-1] || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[LAT_TOTAL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT_TOTAL-2:0], i_in_valid};
        end
    end

    // ---------------- vertex lanes ----------------
    logic signed [31:0] vin_x [0:2];
    logic signed [31:0] vin_y [0:2];
    logic signed [31:0] vin_z [0:2];
    logic signed [31:0] scr_x [0:2];
    logic signed [31:0] scr_y [0:2];
    logic [2:0]         outside;

    assign vin_x[0] = i_in_data.a_x;
    assign vin_y[0] = i_in_data.a_y;
    assign vin_z[0] = i_in_data.a_z;
    assign vin_x[1] = i_in_data.b_x;
    assign vin_y[1] = i_in_data.b_y;
    assign vin_z[1] = i_in_data.b_z;
    assign vin_x[2] = i_in_data.c_x;
    assign vin_y[2] = i_in_data.c_y;
    assign vin_z[2] = i_in_data.c_z;

    for (genvar v = 0; v < 3; v++) begin : g_lane
        logic signed [W_NUM-1:0]   ux, uy;
        logic signed [W_DEPTH-1:0] depth;
        logic signed [W_NDC-1:0]   nx, ny;

        tppc_front u_front (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_x      (vin_x[v]),
            .i_y      (vin_y[v]),
            .i_z      (vin_z[v]),
            .i_off_x  (r_off_x),
            .i_off_y  (r_off_y),
            .i_off_z  (r_off_z),
            .i_aspect (r_aspect),
            .o_ux     (ux),
            .o_uy     (uy),
            .o_depth  (depth)
        );

        // x and y share the depth but divide in separate pipelines
        tppc_div u_div_x (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (ux),
            .i_den (depth),
            .o_q   (nx)
        );

        tppc_div u_div_y (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (uy),
            .i_den (depth),
            .o_q   (ny)
        );

        // y axis flips inside the mapper: (1-y)*H/2
        tppc_screen u_screen (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_nx      (nx),
            .i_ny      (ny),
            .i_w       (r_scr_w),
            .i_h       (r_scr_h),
            .o_x       (scr_x[v]),
            .o_y       (scr_y[v]),
            .o_outside (outside[v])
        );
    end

    // ---------------- merge stage / output register ----------------
    // Triangle is drawn if any vertex lands on screen and the object is in front.
    t_tri_out r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.scr_a_x     <= scr_x[0];
            r_out.scr_a_y     <= scr_y[0];
            r_out.scr_b_x     <= scr_x[1];
            r_out.scr_b_y     <= scr_y[1];
            r_out.scr_c_x     <= scr_x[2];
            r_out.scr_c_y     <= scr_y[2];
            r_out.draw_enable <= (r_off_z > 32'sd0) && !(&outside);
        end
    end

    assign o_out_data = r_out;

    // ---------------- assertions ----------------
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("pipeline advanced while output beat held");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && i_in_valid) |=> r_vld[0])
        else $error("accepted beat not tracked");

endmodule

// File: hdl/tppc_front.sv
module tppc_front (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [31:0]               i_x,
    input  logic signed [31:0]               i_y,
    input  logic signed [31:0]               i_z,
    input  logic signed [31:0]               i_off_x,
    input  logic signed [31:0]               i_off_y,
    input  logic signed [31:0]               i_off_z,
    input  logic [15:0]                      i_aspect,
    output logic signed [tppc_pkg::W_NUM-1:0]   o_ux,
    output logic signed [tppc_pkg::W_NUM-1:0]   o_uy,
    output logic signed [tppc_pkg::W_DEPTH-1:0] o_depth
);
    import tppc_pkg::*;

    logic signed [W_SUM-1:0]   r_sx, r_sy, r_sz;
    logic signed [63:0]        r_pz, r_px, r_py;
    logic signed [W_DEPTH-1:0] r_d3, r_d4, r_d5;
    logic signed [41:0]        r_tx;
    logic signed [34:0]        r_uy3, r_uy4, r_uy5;
    logic signed [63:0]        r_pux;
    logic signed [W_NUM-1:0]   r_ux5;
    logic signed [16:0]        asp_s;
    logic signed [63:0]        rd_z, rd_x, rd_y, rd_u;

    assign asp_s = $signed({1'b0, i_aspect});
    assign rd_z  = f_rnd(r_pz, 30);
    assign rd_x  = f_rnd(r_px, 8);
    assign rd_y  = f_rnd(r_py, 20);
    assign rd_u  = f_rnd(r_pux, 20);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // offset sums
            r_sx <= W_SUM'(i_x) + W_SUM'(i_off_x);
            r_sy <= W_SUM'(i_y) + W_SUM'(i_off_y);
            r_sz <= W_SUM'(i_z) + W_SUM'(i_off_z);
            // products
            r_pz <= 64'(r_sz) * 64'(K_Q_Q30);
            r_px <= 64'(r_sx) * 64'(asp_s);
            r_py <= 64'(r_sy) * 64'(K_FOURPI);
            // rounding
            r_d3  <= W_DEPTH'(rd_z) - K_NEARQ_Q16;
            r_tx  <= 42'(rd_x);
            r_uy3 <= 35'(rd_y);
            // x gets 4/pi after aspect
            r_pux <= 64'(r_tx) * 64'(K_FOURPI);
            r_d4  <= r_d3;
            r_uy4 <= r_uy3;
            r_ux5 <= W_NUM'(rd_u);
            r_d5  <= r_d4;
            r_uy5 <= r_uy4;
        end
    end

    assign o_ux    = r_ux5;
    assign o_uy    = W_NUM'(r_uy5);
    assign o_depth = r_d5;

endmodule

// File: hdl/tppc_div.sv
module tppc_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [tppc_pkg::W_NUM-1:0]   i_num,
    input  logic signed [tppc_pkg::W_DEPTH-1:0] i_den,
    output logic signed [tppc_pkg::W_NDC-1:0]   o_q
);
    import tppc_pkg::*;

    typedef struct packed {
        logic neg;   // quotient negative
        logic ovf;   // quotient >= 2^46
        logic dz;    // zero divisor
        logic nneg;  // numerator negative
    } t_div_flags;

    logic [57:0]               mag_n;
    logic [W_DEPTH-1:0]        mag_d;
    logic [W_NUM-2:0]          abs_n;

    logic [W_DEPTH-1:0]        r_rem  [0:N_QBITS];
    logic [N_QBITS-1:0]        r_low  [0:N_QBITS];
    logic [N_QBITS-1:0]        r_quo  [0:N_QBITS];
    logic [W_DEPTH-1:0]        r_den  [0:N_QBITS];
    t_div_flags                r_flg  [0:N_QBITS];
    logic signed [W_NDC-1:0]   r_q;

    assign abs_n = i_num[W_NUM-1] ? (W_NUM-1)'(-i_num) : (W_NUM-1)'(i_num);
    assign mag_n = {abs_n, 16'd0};
    assign mag_d = i_den[W_DEPTH-1] ? W_DEPTH'(-i_den) : W_DEPTH'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]      <= W_DEPTH'(mag_n[57:N_QBITS]);
            r_low[0]      <= mag_n[N_QBITS-1:0];
            r_quo[0]      <= '0;
            r_den[0]      <= mag_d;
            r_flg[0].neg  <= i_num[W_NUM-1] ^ i_den[W_DEPTH-1];
            r_flg[0].ovf  <= W_DEPTH'(mag_n[57:N_QBITS]) >= mag_d;
            r_flg[0].dz   <= (mag_d == '0);
            r_flg[0].nneg <= i_num[W_NUM-1];
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= N_QBITS; k++) begin : g_stage
        logic [W_DEPTH:0] trial;
        logic             fit;
        assign trial = {r_rem[k-1], r_low[k-1][N_QBITS-1]};
        assign fit   = trial >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= fit ? W_DEPTH'(trial - {1'b0, r_den[k-1]}) : W_DEPTH'(trial);
                r_low[k] <= {r_low[k-1][N_QBITS-2:0], 1'b0};
                r_quo[k] <= {r_quo[k-1][N_QBITS-2:0], fit};
                r_den[k] <= r_den[k-1];
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    logic [N_QBITS-1:0] mag_q;
    t_div_flags         fl;
    assign fl    = r_flg[N_QBITS];
    assign mag_q = (fl.ovf || r_quo[N_QBITS] > K_NDC_LIM) ? K_NDC_LIM : r_quo[N_QBITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (fl.dz) begin
                r_q <= fl.nneg ? -$signed({1'b0, K_NDC_LIM}) : $signed({1'b0, K_NDC_LIM});
            end else begin
                r_q <= fl.neg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
            end
        end
    end

    assign o_q = r_q;

endmodule

// File: hdl/tppc_screen.sv
module tppc_screen (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [tppc_pkg::W_NDC-1:0] i_nx,
    input  logic signed [tppc_pkg::W_NDC-1:0] i_ny,
    input  logic [12:0]                      i_w,
    input  logic [12:0]                      i_h,
    output logic signed [31:0]               o_x,
    output logic signed [31:0]               o_y,
    output logic                             o_outside
);
    import tppc_pkg::*;

    localparam logic signed [47:0] K_CLAMP = 48'sd8589934591; // 2^33-1, saturates anyway

    logic signed [47:0] vx, vy;
    logic signed [33:0] cx, cy;
    logic signed [47:0] r_px, r_py;
    logic signed [31:0] sx, sy;
    logic signed [31:0] r_x, r_y;
    logic               r_out;

    assign vx = K_ONE_Q16 + 48'(i_nx);
    assign vy = K_ONE_Q16 - 48'(i_ny);

    function automatic logic signed [33:0] f_clamp(input logic signed [47:0] v);
        if (v > K_CLAMP)       f_clamp = 34'(K_CLAMP);
        else if (v < -K_CLAMP) f_clamp = 34'(-K_CLAMP);
        else                   f_clamp = 34'(v);
    endfunction

    function automatic logic signed [31:0] f_half_sat(input logic signed [47:0] p);
        logic signed [47:0] r;
        r = p[47] ? (p >>> 1) : ((p + 48'sd1) >>> 1);
        if (r > 48'sd2147483647)       f_half_sat = 32'sh7FFF_FFFF;
        else if (r < -48'sd2147483648) f_half_sat = 32'sh8000_0000;
        else                           f_half_sat = 32'(r);
    endfunction

    assign cx = f_clamp(vx);
    assign cy = f_clamp(vy);
    assign sx = f_half_sat(r_px);
    assign sy = f_half_sat(r_py);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= 48'(cx) * 48'($signed({1'b0, i_w}));
            r_py  <= 48'(cy) * 48'($signed({1'b0, i_h}));
            r_x   <= sx;
            r_y   <= sy;
            r_out <= sx[31] || 33'(sx) > $signed({4'd0, i_w, 16'd0}) ||
                     sy[31] || 33'(sy) > $signed({4'd0, i_h, 16'd0});
        end
    end

    assign o_x       = r_x;
    assign o_y       = r_y;
    assign o_outside = r_out;

endmodule

// File: tb/sv/triangle_perspective_project_cull_checker.sv
module triangle_perspective_project_cull_checker
    import tppc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_tri_in    i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_tri_out   i_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [31:0] i_cfg_val,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint NDC_LIM = 64'sd35184372088832;

    longint ofs_x, ofs_y, ofs_z;
    longint scr_w, scr_h, gain;
    t_tri_out proj_q[$];
    int errors;
    int results;

    assign o_errors  = errors;
    assign o_pending = proj_q.size();
    assign o_results = results;

    function automatic longint rnd_shift(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 << (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint ndc_quot(longint num, longint den);
        longint q;
        if (den == 0) return (num < 0) ? -NDC_LIM : NDC_LIM;
        q = (num * 65536) / den;
        if (q > NDC_LIM) q = NDC_LIM;
        if (q < -NDC_LIM) q = -NDC_LIM;
        return q;
    endfunction

    function automatic longint to_pixels(longint ndc, longint size);
        longint r;
        r = rnd_shift((65536 + ndc) * size, 1);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic t_tri_out project_tri(t_tri_in t);
        t_tri_out r;
        logic signed [31:0] vin[9];
        longint sx, sy, sz, depth, ux, uy, px, py;
        bit all_out;
        vin = '{t.a_x, t.a_y, t.a_z, t.b_x, t.b_y, t.b_z, t.c_x, t.c_y, t.c_z};
        all_out = 1;
        for (int v = 0; v < 3; v++) begin
            sx = longint'(vin[3*v]) + ofs_x;
            sy = longint'(vin[3*v+1]) + ofs_y;
            sz = longint'(vin[3*v+2]) + ofs_z;
            depth = rnd_shift(sz * 64'sd1073849209, 30) - 6554;
            ux = rnd_shift(rnd_shift(sx * gain, 8) * 64'sd1335088, 20);
            uy = rnd_shift(sy * 64'sd1335088, 20);
            px = to_pixels(ndc_quot(ux, depth), scr_w);
            py = to_pixels(-ndc_quot(uy, depth), scr_h);
            if (!(px < 0 || px > scr_w * 65536 || py < 0 || py > scr_h * 65536))
                all_out = 0;
            case (v)
                0: begin r.scr_a_x = 32'(px); r.scr_a_y = 32'(py); end
                1: begin r.scr_b_x = 32'(px); r.scr_b_y = 32'(py); end
                default: begin r.scr_c_x = 32'(px); r.scr_c_y = 32'(py); end
            endcase
        end
        r.draw_enable = (ofs_z > 0) && !all_out;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp);
        errors++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
    endtask

    always @(posedge i_clk) begin
        t_tri_out e;
        if (!i_rst_n) begin
            ofs_x = 0; ofs_y = 0; ofs_z = 0;
            scr_w = 800; scr_h = 600; gain = 256;
            proj_q.delete();
            errors = errors;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OFFSET_X: ofs_x = longint'($signed(i_cfg_val));
                    REG_OFFSET_Y: ofs_y = longint'($signed(i_cfg_val));
                    REG_OFFSET_Z: ofs_z = longint'($signed(i_cfg_val));
                    REG_SCREEN_W: scr_w = i_cfg_val[12:0];
                    REG_SCREEN_H: scr_h = i_cfg_val[12:0];
                    REG_ASPECT:   gain  = i_cfg_val[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (proj_q.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    e = proj_q.pop_front();
                    if (i_out_data.scr_a_x !== e.scr_a_x)
                        report_mismatch("scr_a_x", i_out_data.scr_a_x, e.scr_a_x);
                    if (i_out_data.scr_a_y !== e.scr_a_y)
                        report_mismatch("scr_a_y", i_out_data.scr_a_y, e.scr_a_y);
                    if (i_out_data.scr_b_x !== e.scr_b_x)
                        report_mismatch("scr_b_x", i_out_data.scr_b_x, e.scr_b_x);
                    if (i_out_data.scr_b_y !== e.scr_b_y)
                        report_mismatch("scr_b_y", i_out_data.scr_b_y, e.scr_b_y);
                    if (i_out_data.scr_c_x !== e.scr_c_x)
                        report_mismatch("scr_c_x", i_out_data.scr_c_x, e.scr_c_x);
                    if (i_out_data.scr_c_y !== e.scr_c_y)
                        report_mismatch("scr_c_y", i_out_data.scr_c_y, e.scr_c_y);
                    if (i_out_data.draw_enable !== e.draw_enable)
                        report_mismatch("draw_enable", i_out_data.draw_enable,
                                        e.draw_enable);
                end
            end
            if (i_in_valid && !i_in_stall)
                proj_q.push_back(project_tri(i_in_data));
        end
    end

    initial begin
        errors = 0;
        results = 0;
    end

endmodule

// File: tb/sv/triangle_perspective_project_cull_test.sv
module triangle_perspective_project_cull_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tppc_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    t_tri_in     in_data = '0;
    logic        out_valid;
    logic        out_stall = 0;
    t_tri_out    out_data;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending, results;
    int beats_sent = 0;
    int cfg_writes = 0;
    bit sink_hold = 0;  // sink draws stalls only while set

    always begin
        #6 clk = 1;
        #6 clk = 0;
    end

    triangle_perspective_project_cull dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // checker sees a write on the access cycle edge, same as the block
    triangle_perspective_project_cull_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(psel && penable && pwrite && pready),
        .i_cfg_idx(paddr[4:2]), .i_cfg_val(pwdata),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // APB write: setup then access, held until pready
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        cfg_writes++;
    endtask

    // wait for the pipe to drain before touching registers
    task automatic drain_pipe();
        while (pending != 0) @(posedge clk);
        repeat (LAT_TOTAL + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;                                   // anything
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000); // near zero
            default: return 32'($signed($urandom_range(0, 40)) - 20) << 16
                            | $urandom_range(0, 16'hffff);
        endcase
    endfunction

    function automatic t_tri_in rand_tri();
        t_tri_in t;
        t.a_x = rand_coord(); t.a_y = rand_coord();
        t.b_x = rand_coord(); t.b_y = rand_coord();
        t.c_x = rand_coord(); t.c_y = rand_coord();
        // depth mostly in front of the viewer so points land on screen
        t.a_z = $urandom_range(0, 3) == 0 ? rand_coord() : $urandom_range(1, 32'h0040_0000);
        t.b_z = $urandom_range(0, 3) == 0 ? rand_coord() : $urandom_range(1, 32'h0040_0000);
        t.c_z = $urandom_range(0, 3) == 0 ? rand_coord() : $urandom_range(1, 32'h0040_0000);
        return t;
    endfunction

    // one input beat after a random gap; valid stays up across back-to-back beats
    task automatic send_tri(t_tri_in t);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        in_data <= t;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic idle_input();
        in_valid <= 0;
    endtask

    // sink stalls: per beat a random number of stall cycles
    initial begin
        int n;
        forever begin
            @(negedge clk);
            n = sink_hold ? $urandom_range(0, 6) : 0;
            if (n != 0) begin
                out_stall <= 1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        t_tri_in t;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: reset settings, offset_z still zero so nothing draws
        t = '0;
        send_tri(t);
        t = '{default: 32'h7fff_ffff}; send_tri(t);
        t = '{default: 32'h8000_0000}; send_tri(t);
        idle_input();
        drain_pipe();

        reg_write(REG_OFFSET_Z, 32'h0005_0000);
        // origin, on-screen point, a vertex nearer than the near plane, a vertex behind
        t = '0; send_tri(t);
        t = '{a_x: 32'h0001_0000, a_y: 32'hffff_0000, a_z: 32'h0, default: 32'h0};
        send_tri(t);
        t = '{a_z: 32'hfffb_0000 + 32'd6554 / 2, default: 32'h0000_8000};
        send_tri(t);
        t = '{a_z: 32'hfffb_0000, b_z: 32'hfffb_0000, c_z: 32'hfffb_0000,
              default: 32'h0001_0000};
        send_tri(t);
        t = '{default: 32'h7fff_ffff}; send_tri(t);
        t = '{default: 32'h8000_0000}; send_tri(t);
        t = '{a_x: 32'h8000_0000, a_y: 32'h7fff_ffff, a_z: 32'h0000_0001,
              default: 32'hffff_ffff};
        send_tri(t);
        // all vertices far off screen: culled
        t = '{a_x: 32'h0100_0000, b_x: 32'h0100_0000, c_x: 32'h0100_0000,
              default: 32'h0000_0100};
        send_tri(t);
        idle_input();
        drain_pipe();

        // extreme registers: zero size, size 4096, zero and max aspect
        reg_write(REG_SCREEN_W, 32'd0);
        reg_write(REG_SCREEN_H, 32'd4096);
        reg_write(REG_ASPECT, 32'd0);
        reg_write(REG_OFFSET_X, 32'h7fff_ffff);
        reg_write(REG_OFFSET_Y, 32'h8000_0000);
        repeat (4) send_tri(rand_tri());
        idle_input();
        drain_pipe();
        reg_write(REG_SCREEN_W, 32'd4096);
        reg_write(REG_SCREEN_H, 32'd1);
        reg_write(REG_ASPECT, 32'hffff);
        reg_write(REG_OFFSET_X, 32'h8000_0000);
        reg_write(REG_OFFSET_Y, 32'h7fff_ffff);
        reg_write(REG_OFFSET_Z, 32'h8000_0000);
        repeat (4) send_tri(rand_tri());
        idle_input();
        drain_pipe();

        // random phases, each under a fresh register setting
        sink_hold = 1;
        for (int ph = 0; ph < 12; ph++) begin
            reg_write(REG_OFFSET_X, ph % 3 == 0 ? $urandom : rand_coord());
            reg_write(REG_OFFSET_Y, ph % 3 == 0 ? $urandom : rand_coord());
            reg_write(REG_OFFSET_Z, ph % 4 == 3 ? $urandom
                                    : $urandom_range(1, 32'h0020_0000));
            reg_write(REG_SCREEN_W, ph % 5 == 0 ? $urandom_range(0, 8191)
                                    : $urandom_range(1, 4096));
            reg_write(REG_SCREEN_H, ph % 5 == 0 ? $urandom_range(0, 8191)
                                    : $urandom_range(1, 4096));
            reg_write(REG_ASPECT, $urandom_range(0, 16'hffff));
            // every fourth phase runs without gaps or stalls
            sink_hold = (ph % 4 != 1);
            for (int k = 0; k < 140; k++) begin
                if (ph % 4 == 1) begin
                    in_valid <= 1;
                    in_data <= rand_tri();
                    do @(posedge clk); while (in_stall);
                    @(negedge clk);
                    beats_sent++;
                end else begin
                    send_tri(rand_tri());
                end
            end
            idle_input();
            drain_pipe();
            sink_hold = 1;
        end

        $display("Sent %0d triangles, checked %0d results, %0d register writes.",
                 beats_sent, results, cfg_writes);
        $display("Covered reset settings, extreme sizes/offsets/aspect, stalls and gaps.");
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout");
        $display("Regression FAIL");
        $finish;
    end

endmodule
